// ===== sv/cps_pkg.sv =====
// Package for the closest-point-on-segment unit: widths, codes and the
// per-stage data types shared by the cell modules and the top level.
// No dependencies.
package cps_pkg;

  localparam int CoordBits = 24;
  localparam int AlphaBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int DotBits   = 2 * DiffBits + 2;
  localparam int SqBits    = 2 * DiffBits + 2;
  localparam int DistBits  = CoordBits + 1;
  localparam int RootBits  = SqBits / 2;

  typedef enum logic [1:0] {
    WHERE_INTERIOR = 2'd0,
    WHERE_START    = 2'd1,
    WHERE_END      = 2'd2,
    WHERE_DEGEN    = 2'd3
  } where_t;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;

  // Payload that travels along the divider chain.
  typedef struct packed {
    coord_t [2:0]          q;
    coord_t [2:0]          s;
    diff_t  [2:0]          line;
    logic [DotBits-1:0]    rem;
    logic [DotBits-1:0]    den;
    logic [AlphaBits-1:0]  alpha;
    where_t                where;
  } div_t;

  // Payload that travels along the square-root chain. The partial root is
  // kept scaled by the current trial bit, so it needs the full square width.
  typedef struct packed {
    coord_t [2:0]          near;
    where_t                where;
    logic [SqBits-1:0]     rem;
    logic [SqBits-1:0]     root;
  } sqrt_t;

endpackage

// ===== sv/closest_point_on_segment_unit.sv =====
// Closest point on a 3-D segment, with floored distance.
// Stages in order: differences, dot products, divider cells, product, near point, squared distance, root cells.
// Throughput: one request per cycle; each divider and root cell is a stage.
// The whole pipeline stalls only when the output register is full and held.
// Reset (rst_n, synchronous, active low) clears all valid bits.
module closest_point_on_segment_unit
  import cps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CoordBits-1:0] in_query_x,
  input  logic [CoordBits-1:0] in_query_y,
  input  logic [CoordBits-1:0] in_query_z,
  input  logic [CoordBits-1:0] in_start_x,
  input  logic [CoordBits-1:0] in_start_y,
  input  logic [CoordBits-1:0] in_start_z,
  input  logic [CoordBits-1:0] in_end_x,
  input  logic [CoordBits-1:0] in_end_y,
  input  logic [CoordBits-1:0] in_end_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CoordBits-1:0] out_near_x,
  output logic [CoordBits-1:0] out_near_y,
  output logic [CoordBits-1:0] out_near_z,
  output logic [DistBits-1:0]  out_distance,
  output logic [1:0]           out_where_found
);

  localparam int NStages = 2 + AlphaBits + 3 + RootBits;
  localparam int Sq0 = 2 + AlphaBits + 3;

  logic [NStages-1:0] vld_r;
  logic               en;

  // Advance whenever the last stage is empty or being drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[NStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NStages-2:0], in_valid};
    end
  end

  // Stage 1: differences.
  coord_t [2:0] q1_r, s1_r, e1_r;
  diff_t  [2:0] line1_r, qs1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q1_r <= {in_query_z, in_query_y, in_query_x};
      s1_r <= {in_start_z, in_start_y, in_start_x};
      e1_r <= {in_end_z, in_end_y, in_end_x};
      line1_r[0] <= DiffBits'(signed'(in_end_x)) - DiffBits'(signed'(in_start_x));
      line1_r[1] <= DiffBits'(signed'(in_end_y)) - DiffBits'(signed'(in_start_y));
      line1_r[2] <= DiffBits'(signed'(in_end_z)) - DiffBits'(signed'(in_start_z));
      qs1_r[0] <= DiffBits'(signed'(in_query_x)) - DiffBits'(signed'(in_start_x));
      qs1_r[1] <= DiffBits'(signed'(in_query_y)) - DiffBits'(signed'(in_start_y));
      qs1_r[2] <= DiffBits'(signed'(in_query_z)) - DiffBits'(signed'(in_start_z));
    end
  end

  // Stage 2: dot products and the case decision.
  logic signed [DotBits-1:0] num2, den2;
  div_t                      d0;
  always_comb begin
    num2 = '0;
    den2 = '0;
    for (int i = 0; i < 3; i++) begin
      num2 = num2 + DotBits'(line1_r[i]) * DotBits'(qs1_r[i]);
      den2 = den2 + DotBits'(line1_r[i]) * DotBits'(line1_r[i]);
    end
    d0.q     = q1_r;
    d0.s     = s1_r;
    d0.line  = line1_r;
    d0.den   = den2;
    d0.rem   = num2;
    d0.alpha = '0;
    if (den2 == '0) begin
      d0.where = WHERE_DEGEN;
    end else if (num2 <= 0) begin
      d0.where = WHERE_START;
    end else if (num2 >= den2) begin
      d0.where = WHERE_END;
      d0.line  = line1_r;
      d0.s     = e1_r;
    end else begin
      d0.where = WHERE_INTERIOR;
    end
  end

  div_t div_r [AlphaBits+1];
  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= d0;
    end
  end

  // Divider chain: one quotient bit per cell.
  for (genvar g = 0; g < AlphaBits; g++) begin : g_div
    cps_div_cell u_cell (.clk(clk), .en(en), .din(div_r[g]), .dout(div_r[g+1]));
  end

  // Interpolation: product with rounding offset, then shift and add, then squared distance.
  div_t dl;
  assign dl = div_r[AlphaBits];
  logic signed [DiffBits+AlphaBits+1:0] prod_r [3];
  coord_t [2:0] s_p_r, q_p_r;
  where_t       w_p_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= dl.line[i] * $signed({1'b0, dl.alpha})
                     + (DiffBits+AlphaBits+2)'(1 << (AlphaBits-1));
      end
      s_p_r <= dl.s;
      q_p_r <= dl.q;
      w_p_r <= dl.where;
    end
  end

  coord_t [2:0] near_r, q_n_r;
  where_t       w_n_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (w_p_r == WHERE_INTERIOR) begin
          near_r[i] <= s_p_r[i] + CoordBits'(prod_r[i] >>> AlphaBits);
        end else begin
          near_r[i] <= s_p_r[i];
        end
      end
      q_n_r <= q_p_r;
      w_n_r <= w_p_r;
    end
  end

  // Squared distance.
  diff_t             dd [3];
  logic [SqBits-1:0] dsq;
  always_comb begin
    dsq = '0;
    for (int i = 0; i < 3; i++) begin
      dd[i] = DiffBits'(signed'(q_n_r[i])) - DiffBits'(signed'(near_r[i]));
      dsq   = dsq + unsigned'(SqBits'(dd[i]) * SqBits'(dd[i]));
    end
  end

  sqrt_t sq_r [RootBits+1];
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].near  <= near_r;
      sq_r[0].where <= w_n_r;
      sq_r[0].rem   <= dsq;
      sq_r[0].root  <= '0;
    end
  end

  // Root chain: one root bit per cell, trial bit from the top down.
  for (genvar g = 0; g < RootBits; g++) begin : g_sqrt
    localparam logic [SqBits-1:0] BitW = SqBits'(1) << (SqBits - 2 - 2 * g);
    cps_sqrt_cell u_cell (
      .clk(clk), .en(en), .bit_w(BitW), .din(sq_r[g]), .dout(sq_r[g+1])
    );
  end

  assign out_near_x      = sq_r[RootBits].near[0];
  assign out_near_y      = sq_r[RootBits].near[1];
  assign out_near_z      = sq_r[RootBits].near[2];
  assign out_distance    = DistBits'(sq_r[RootBits].root);
  assign out_where_found = sq_r[RootBits].where;

  // A stalled result holds its distance and x coordinate.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_near_x))
    else $error("result changed while stalled");

  // Ready follows the output stage only.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready mismatch");

  // A request in the first root stage moves on whenever the pipeline advances.
  assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[Sq0] |=> vld_r[Sq0+1])
    else $error("pipeline lost an item");

endmodule

// ===== sv/cps_div_cell.sv =====
// One restoring-division cell: produces one quotient bit of alpha.
// Depends on cps_pkg.
module cps_div_cell
  import cps_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  logic [DotBits:0] shifted;
  logic [DotBits:0] trial;
  div_t             res;

  // Shift the remainder and try a subtract of the divisor.
  always_comb begin
    shifted = {din.rem, 1'b0};
    trial   = shifted - {1'b0, din.den};
    res     = din;
    if (!trial[DotBits]) begin
      res.rem   = trial[DotBits-1:0];
      res.alpha = {din.alpha[AlphaBits-2:0], 1'b1};
    end else begin
      res.rem   = shifted[DotBits-1:0];
      res.alpha = {din.alpha[AlphaBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= res;
    end
  end

endmodule

// ===== sv/cps_sqrt_cell.sv =====
// One square-root cell: settles one bit of the root per stage.
// Depends on cps_pkg.
module cps_sqrt_cell
  import cps_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SqBits-1:0] bit_w,
  input  sqrt_t             din,
  output sqrt_t             dout
);

  logic [SqBits:0] trial;
  sqrt_t           res;

  // Digit-by-digit root: compare rem against root + bit.
  always_comb begin
    res   = din;
    trial = {1'b0, din.rem} - ({1'b0, din.root} + {1'b0, bit_w});
    if (!trial[SqBits]) begin
      res.rem  = trial[SqBits-1:0];
      res.root = (din.root >> 1) + bit_w;
    end else begin
      res.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= res;
    end
  end

endmodule
